@@ hw/rtl/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the ring buffer deque
// Word layouts of the request and response channels, operation and status
// codes, and the sequencer states.
// ----------------------------------------------------------------------------
package rbd_pkg;

	// Default geometry
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths of the channel words
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_READ       = 3'd4,
		ACT_WRITE      = 3'd5,
		ACT_INSERT     = 3'd6,
		ACT_ERASE      = 3'd7
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INS,
		S_INS_WR,
		S_ERS,
		S_ERS_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		action_t              action;
		logic [VALUE_W-1:0]   item_value;
		logic [POS_W-1:0]     position;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0]   read_value;
		logic [COUNT_W-1:0]   entry_count;
		status_t              status;
	} rsp_t;

endpackage

@@ hw/rtl/rbd_req_if.sv @@
// ----------------------------------------------------------------------------
// rbd_req_if: request channel of the ring buffer deque
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface rbd_req_if;
	logic          valid;
	logic          ready;
	rbd_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/rbd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rbd_rsp_if: response channel of the ring buffer deque
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface rbd_rsp_if;
	logic          valid;
	logic          ready;
	rbd_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/ring_buffer_deque.sv @@
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue in a circular single-port store
// Push, pop, read, write: an accepted word passes S_EXEC and S_DONE, and the
// response register is loaded from S_DONE. Insert and erase add a read and
// write loop; the next word is taken in S_IDLE after the response load.
// Each moved word costs a read and a write step on the one store port, and
// one slot adder (head + logical index, modulo DEPTH) forms every address.
// One request is worked at a time; a finished word waits in the response
// register while the next request is taken, and a held response stalls the
// sequencer before it loads the next one. Reset empties the deque at once.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
	parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	rbd_req_if.sink   req,
	rbd_rsp_if.source rsp
);

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > rbd_pkg::POS_W) ? CNT_W : rbd_pkg::POS_W;
	localparam int EXT_W  = DATA_WIDTH + rbd_pkg::VALUE_W;

	rbd_pkg::state_t  state_q, state_d;
	rbd_pkg::action_t action_q;
	rbd_pkg::status_t status_q, status_d;
	logic [DATA_WIDTH-1:0]     value_q;
	logic [rbd_pkg::POS_W-1:0] pos_q;
	logic [SLOT_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  mem_we, mem_re;
	logic [DATA_WIDTH-1:0] mem_wdata;

	logic          rsp_valid_q;
	rbd_pkg::rsp_t rsp_q;
	logic          rsp_load;

	logic [SLOT_W-1:0] lidx;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot;

	logic [EXT_W-1:0] val_ext, rd_ext;
	logic             full, empty;
	logic [CMP_W-1:0] pos_x, cnt_x;
	logic             accept;

	// Shared slot unit: head plus logical index, wrapped once
	assign slot_sum = {1'b0, head_q} + {1'b0, lidx};
	assign slot = (slot_sum >= (SLOT_W+1)'(DEPTH)) ?
		SLOT_W'(slot_sum - (SLOT_W+1)'(DEPTH)) : SLOT_W'(slot_sum);

	// Fit the 32-bit channel value to the stored width and back
	assign val_ext = EXT_W'(req.data.item_value);
	assign rd_ext  = EXT_W'(rdata_q);

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign pos_x  = CMP_W'(pos_q);
	assign cnt_x  = CMP_W'(count_q);
	assign accept = req.valid && req.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, store controls and pointer updates
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		status_d  = status_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		lidx      = SLOT_W'(pos_q);
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = value_q;
		rsp_load  = 1'b0;
		unique case (state_q)
			rbd_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = rbd_pkg::S_EXEC;
				end
			end
			rbd_pkg::S_EXEC: begin
				status_d = rbd_pkg::STAT_OK;
				state_d  = rbd_pkg::S_DONE;
				case (action_q)
					rbd_pkg::ACT_PUSH_FRONT: begin
						lidx = SLOT_W'(DEPTH - 1);
						if (full) begin
							status_d = rbd_pkg::STAT_FULL;
						end else begin
							mem_we  = 1'b1;
							head_d  = slot;
							count_d = count_q + CNT_W'(1);
						end
					end
					rbd_pkg::ACT_PUSH_BACK: begin
						lidx = SLOT_W'(count_q);
						if (full) begin
							status_d = rbd_pkg::STAT_FULL;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end
					rbd_pkg::ACT_POP_FRONT: begin
						lidx = SLOT_W'(1);
						if (empty) begin
							status_d = rbd_pkg::STAT_EMPTY;
						end else begin
							head_d  = slot;
							count_d = count_q - CNT_W'(1);
						end
					end
					rbd_pkg::ACT_POP_BACK: begin
						if (empty) begin
							status_d = rbd_pkg::STAT_EMPTY;
						end else begin
							count_d = count_q - CNT_W'(1);
						end
					end
					rbd_pkg::ACT_READ: begin
						if (pos_x >= cnt_x) begin
							status_d = rbd_pkg::STAT_RANGE;
						end else begin
							mem_re = 1'b1;
						end
					end
					rbd_pkg::ACT_WRITE: begin
						if (pos_x >= cnt_x) begin
							status_d = rbd_pkg::STAT_RANGE;
						end else begin
							mem_we = 1'b1;
						end
					end
					rbd_pkg::ACT_INSERT: begin
						if (pos_x > cnt_x) begin
							status_d = rbd_pkg::STAT_RANGE;
						end else if (full) begin
							status_d = rbd_pkg::STAT_FULL;
						end else begin
							idx_d   = count_q;
							state_d = rbd_pkg::S_INS;
						end
					end
					default: begin
						if (pos_x >= cnt_x) begin
							status_d = rbd_pkg::STAT_RANGE;
						end else begin
							idx_d   = CNT_W'(pos_q);
							state_d = rbd_pkg::S_ERS;
						end
					end
				endcase
			end
			// Insert: move words back from the tail down to the gap
			rbd_pkg::S_INS: begin
				if (CMP_W'(idx_q) == pos_x) begin
					lidx    = SLOT_W'(idx_q);
					mem_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
					state_d = rbd_pkg::S_DONE;
				end else begin
					lidx    = SLOT_W'(idx_q - CNT_W'(1));
					mem_re  = 1'b1;
					state_d = rbd_pkg::S_INS_WR;
				end
			end
			rbd_pkg::S_INS_WR: begin
				lidx      = SLOT_W'(idx_q);
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
				idx_d     = idx_q - CNT_W'(1);
				state_d   = rbd_pkg::S_INS;
			end
			// Erase: move words forward over the erased slot
			rbd_pkg::S_ERS: begin
				lidx = SLOT_W'(idx_q + CNT_W'(1));
				if ((idx_q + CNT_W'(1)) >= count_q) begin
					count_d = count_q - CNT_W'(1);
					state_d = rbd_pkg::S_DONE;
				end else begin
					mem_re  = 1'b1;
					state_d = rbd_pkg::S_ERS_WR;
				end
			end
			rbd_pkg::S_ERS_WR: begin
				lidx      = SLOT_W'(idx_q);
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
				idx_d     = idx_q + CNT_W'(1);
				state_d   = rbd_pkg::S_ERS;
			end
			rbd_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = rbd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rbd_pkg::S_IDLE;
			end
		endcase
	end

	// Pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Hold the request word and working index
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.data.action;
			value_q  <= val_ext[DATA_WIDTH-1:0];
			pos_q    <= req.data.position;
		end
		status_q <= status_d;
		idx_q    <= idx_d;
	end

	// Entry store: one port, registered read data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[slot];
		end
	end

	// Response register: load when the previous word has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.read_value  <= (action_q == rbd_pkg::ACT_READ &&
				status_q == rbd_pkg::STAT_OK) ? rd_ext[rbd_pkg::VALUE_W-1:0] : '0;
			rsp_q.entry_count <= rbd_pkg::COUNT_W'(count_q);
			rsp_q.status      <= status_q;
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= SLOT_W'(DEPTH - 1))
		else $error("head slot outside the store");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in the same cycle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == rbd_pkg::S_EXEC)
		else $error("accepted word not taken into execution");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != rbd_pkg::S_EXEC && state_q != rbd_pkg::S_INS &&
		state_q != rbd_pkg::S_ERS |=> $stable(count_q))
		else $error("entry count changed outside an update step");

endmodule
